### sv/sjf_pkg.sv
// package for the shortest-job-first scheduler
// holds sizes, item structs and the cell / pick structs; depends on nothing
package sjf_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int DATA_W = 16;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;
  localparam int JOB_W  = 5;

  typedef struct packed {
    logic [DATA_W-1:0] arrival_time;
    logic [DATA_W-1:0] burst_time;
    logic              final_job;
  } job_t;

  typedef struct packed {
    logic              is_idle;
    logic [JOB_W-1:0]  job_number;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              last_segment;
  } segment_t;

  // contents of one chain cell
  typedef struct packed {
    logic              valid;
    logic              done;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] arrival;
    logic [DATA_W-1:0] burst;
  } cell_t;

  // running result of one scan pass
  typedef struct packed {
    logic              found;
    logic              any;
    logic [IDX_W-1:0]  best_idx;
    logic [DATA_W-1:0] best_arr;
    logic [DATA_W-1:0] best_burst;
    logic [DATA_W-1:0] min_arr;
  } pick_t;

endpackage

### sv/sjf_cell.sv
// one cell of the job chain: holds one job and takes its neighbor's on shift
// depends on sjf_pkg
module sjf_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  logic           clear,
  input  sjf_pkg::cell_t din,
  output sjf_pkg::cell_t q
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q.valid <= 1'b0;
      q.done  <= 1'b0;
    end else if (shift) begin
      q.valid <= din.valid;
      q.done  <= din.done;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      q.idx     <= din.idx;
      q.arrival <= din.arrival;
      q.burst   <= din.burst;
    end
  end

endmodule

### sv/sjf_pick.sv
// scan unit: looks at the chain head once a cycle while en is high, keeps the best ready job
// and the earliest pending arrival; depends on sjf_pkg
module sjf_pick (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       first,
  input  sjf_pkg::cell_t             head,
  input  logic [sjf_pkg::TIME_W-1:0] cur_time,
  output sjf_pkg::pick_t             result
);

  logic found_c;
  logic any_c;
  logic live;
  logic ready;
  logic take;
  logic grab_min;

  assign found_c = first ? 1'b0 : result.found;
  assign any_c   = first ? 1'b0 : result.any;
  assign live    = head.valid && !head.done;
  assign ready   = live && (sjf_pkg::TIME_W'(head.arrival) <= cur_time);
  // strict compares keep the lower index on a full tie
  assign take    = ready && (!found_c || (head.burst < result.best_burst) ||
                   ((head.burst == result.best_burst) &&
                    (head.arrival < result.best_arr)));
  assign grab_min = live && (!any_c || (head.arrival < result.min_arr));

  always_ff @(posedge clk) begin
    if (rst) begin
      result.found <= 1'b0;
      result.any   <= 1'b0;
    end else if (en) begin
      result.found <= found_c || ready;
      result.any   <= any_c || live;
    end
  end

  always_ff @(posedge clk) begin
    if (en && take) begin
      result.best_idx   <= head.idx;
      result.best_arr   <= head.arrival;
      result.best_burst <= head.burst;
    end
    if (en && grab_min) begin
      result.min_arr <= head.arrival;
    end
  end

endmodule

### sv/nonpreemptive_sjf_scheduler.sv
// top level of the non-preemptive shortest-job-first scheduler
// depends on sjf_pkg, sjf_cell and sjf_pick
//
// usage
//   load jobs one item at a time: start high while busy is low accepts the
//   item on job (arrival, burst, final_job). loading accepts one item per cycle
//   and gives no result. items beyond the chain length are dropped.
//   the item with final_job set raises busy and runs the schedule from tick 0.
//   every Gantt segment (job run or merged idle gap) shows on segment for
//   exactly one cycle with valid high; the receiver cannot hold it off.
//   the segment with last_segment set carries the totals, and busy drops in
//   the same cycle, with the job set cleared for the next load.
// decisions
//   each decision is one pass of the job chain through the scan unit (ST_SCAN),
//   then ST_CALC for an idle gap, or ST_CALC, ST_TAT and ST_EMIT for a job
//   run; the chain length sets the pass time.
// reset
//   synchronous rst empties the chain, zeroes the clock and sums, drops busy.
module nonpreemptive_sjf_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sjf_pkg::job_t     job,
  output logic              busy,
  output logic              valid,
  output sjf_pkg::segment_t segment
);

  localparam int N = sjf_pkg::MAX_PROCESSES;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_TAT  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;

  logic [sjf_pkg::CNT_W-1:0]  job_count;
  logic [sjf_pkg::CNT_W-1:0]  completed;
  logic [sjf_pkg::IDX_W-1:0]  scan_cnt;
  logic [sjf_pkg::TIME_W-1:0] cur_time;
  logic [sjf_pkg::SUM_W-1:0]  sum_turnaround;
  logic [sjf_pkg::SUM_W-1:0]  sum_waiting;
  logic                       mark_pending;
  logic [sjf_pkg::IDX_W-1:0]  mark_idx;

  // per-job arithmetic, registered between steps
  logic [sjf_pkg::TIME_W-1:0] start_r;
  logic [sjf_pkg::TIME_W-1:0] end_r;
  logic [sjf_pkg::TIME_W-1:0] wt_r;
  logic [sjf_pkg::TIME_W-1:0] tat_r;

  logic [sjf_pkg::SUM_W-1:0]  sum_turnaround_next;
  logic [sjf_pkg::SUM_W-1:0]  sum_waiting_next;

  sjf_pkg::cell_t cells [N];
  sjf_pkg::cell_t head_upd;
  sjf_pkg::cell_t new_cell;
  sjf_pkg::cell_t tail_in;
  sjf_pkg::pick_t pick;

  logic accept;
  logic room;
  logic shift;
  logic clear_set;
  logic last_job;
  logic scan_end;

  assign busy     = (state != ST_LOAD);
  assign accept   = start && !busy;
  assign room     = job_count < sjf_pkg::CNT_W'(N);
  assign scan_end = scan_cnt == sjf_pkg::IDX_W'(N - 1);
  assign last_job = sjf_pkg::CNT_W'(completed + 1'b1) == job_count;
  assign clear_set = (state == ST_EMIT) && last_job;

  // the chain shifts toward the head on a load and rotates during a pass;
  // loads push in at the tail, so jobs sit in load order ahead of the tail
  assign shift = (accept && room) || (state == ST_SCAN);

  always_comb begin
    new_cell.valid   = 1'b1;
    new_cell.done    = 1'b0;
    new_cell.idx     = sjf_pkg::IDX_W'(job_count);
    new_cell.arrival = job.arrival_time;
    new_cell.burst   = job.burst_time;
  end

  // the job picked last pass is retired as it goes by the head
  always_comb begin
    head_upd      = cells[0];
    head_upd.done = cells[0].done ||
                    (mark_pending && cells[0].valid && (cells[0].idx == mark_idx));
  end

  assign tail_in = (state == ST_SCAN) ? head_upd : new_cell;

  for (genvar i = 0; i < N; i++) begin : g_chain
    if (i == N - 1) begin : g_tail
      sjf_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .clear (clear_set),
        .din   (tail_in),
        .q     (cells[i])
      );
    end else begin : g_body
      sjf_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .clear (clear_set),
        .din   (cells[i+1]),
        .q     (cells[i])
      );
    end
  end

  // scan unit sees the head with the retire mark already applied
  sjf_pick u_pick (
    .clk      (clk),
    .rst      (rst),
    .en       (state == ST_SCAN),
    .first    (scan_cnt == '0),
    .head     (head_upd),
    .cur_time (cur_time),
    .result   (pick)
  );

  assign sum_turnaround_next = sum_turnaround + sjf_pkg::SUM_W'(tat_r);
  assign sum_waiting_next    = sum_waiting + sjf_pkg::SUM_W'(wt_r);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      job_count      <= '0;
      completed      <= '0;
      scan_cnt       <= '0;
      cur_time       <= '0;
      sum_turnaround <= '0;
      sum_waiting    <= '0;
      mark_pending   <= 1'b0;
      valid          <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              job_count <= sjf_pkg::CNT_W'(job_count + 1'b1);
            end
            if (job.final_job) begin
              state        <= ST_SCAN;
              scan_cnt     <= '0;
              completed    <= '0;
              mark_pending <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          scan_cnt <= sjf_pkg::IDX_W'(scan_cnt + 1'b1);
          if (scan_end) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (pick.found) begin
            state <= ST_TAT;
          end else begin
            // nothing ready: one idle gap up to the earliest pending arrival
            valid    <= 1'b1;
            cur_time <= sjf_pkg::TIME_W'(pick.min_arr);
            scan_cnt <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_TAT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          valid        <= 1'b1;
          mark_pending <= 1'b1;
          scan_cnt     <= '0;
          if (last_job) begin
            state          <= ST_LOAD;
            job_count      <= '0;
            completed      <= '0;
            cur_time       <= '0;
            sum_turnaround <= '0;
            sum_waiting    <= '0;
          end else begin
            state          <= ST_SCAN;
            completed      <= sjf_pkg::CNT_W'(completed + 1'b1);
            cur_time       <= end_r;
            sum_turnaround <= sum_turnaround_next;
            sum_waiting    <= sum_waiting_next;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scan_end) begin
      mark_idx <= mark_idx;
    end
    if (state == ST_EMIT) begin
      mark_idx <= pick.best_idx;
    end
  end

  // job arithmetic: end and waiting from the start tick, then turnaround
  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      start_r <= cur_time;
      end_r   <= cur_time + sjf_pkg::TIME_W'(pick.best_burst);
      wt_r    <= cur_time - sjf_pkg::TIME_W'(pick.best_arr);
    end
    if (state == ST_TAT) begin
      tat_r <= end_r - sjf_pkg::TIME_W'(pick.best_arr);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_CALC && !pick.found) begin
      segment.is_idle          <= 1'b1;
      segment.job_number       <= '0;
      segment.start_time       <= cur_time;
      segment.end_time         <= sjf_pkg::TIME_W'(pick.min_arr);
      segment.turnaround       <= '0;
      segment.waiting          <= '0;
      segment.total_turnaround <= '0;
      segment.total_waiting    <= '0;
      segment.last_segment     <= 1'b0;
    end else if (state == ST_EMIT) begin
      segment.is_idle          <= 1'b0;
      segment.job_number       <= sjf_pkg::JOB_W'(pick.best_idx) + sjf_pkg::JOB_W'(1);
      segment.start_time       <= start_r;
      segment.end_time         <= end_r;
      segment.turnaround       <= tat_r;
      segment.waiting          <= wt_r;
      segment.total_turnaround <= last_job ? sum_turnaround_next : '0;
      segment.total_waiting    <= last_job ? sum_waiting_next : '0;
      segment.last_segment     <= last_job;
    end
  end

  // checks
  a_final_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && job.final_job) |=> busy)
    else $error("final item did not start the schedule");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (valid && segment.last_segment) |-> !busy)
    else $error("busy still high with the last segment");

  a_completed_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (completed < job_count))
    else $error("more jobs completed than loaded");

  a_idle_then_scan: assert property (@(posedge clk) disable iff (rst)
    (valid && segment.is_idle) |=> (!valid && state == ST_SCAN))
    else $error("idle gap not followed by a new pass");

endmodule

### bench/nonpreemptive_sjf_scheduler_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the non-preemptive shortest-job-first scheduler
// predicts each Gantt segment from the loaded job set; depends on sjf_pkg and nonpreemptive_sjf_scheduler
module nonpreemptive_sjf_scheduler_tb;

  // longest stretch with neither an accepted item nor a segment; kept wide next to
  // one decision pass and the longest hold-off of the sender
  localparam int STALL_LIMIT = 1000;
  localparam int ITEM_TARGET = 360;
  localparam int SETTLE_CYCLES = 40;

  logic              clk;
  logic              rst;
  logic              start;
  sjf_pkg::job_t     job;
  logic              busy;
  logic              valid;
  sjf_pkg::segment_t segment;

  nonpreemptive_sjf_scheduler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .job(job),
    .busy(busy),
    .valid(valid),
    .segment(segment)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // jobs of the set being loaded, as the scheduler should hold them
  logic [sjf_pkg::DATA_W-1:0] held_arrival [sjf_pkg::MAX_PROCESSES];
  logic [sjf_pkg::DATA_W-1:0] held_burst [sjf_pkg::MAX_PROCESSES];
  int held_count = 0;

  // segments the scheduler owes us, oldest first
  sjf_pkg::segment_t pending_segments [$];

  int mismatches = 0;
  int items_sent = 0;
  int sets_scheduled = 0;
  int dropped_jobs = 0;
  int segments_seen = 0;
  int idle_gaps_seen = 0;
  int stall_cycles = 0;

  // one printed line per mismatch, counted always
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  // schedule predictor: store the job, and on the final job run the whole
  // non-preemptive sjf pass from tick 0 and queue every segment it gives
  task automatic predict_item(input sjf_pkg::job_t j);
    logic [sjf_pkg::TIME_W-1:0] now;
    logic [sjf_pkg::TIME_W-1:0] seg_start;
    logic [sjf_pkg::TIME_W-1:0] tat;
    logic [sjf_pkg::TIME_W-1:0] wt;
    logic [sjf_pkg::TIME_W-1:0] next_arrival;
    logic [sjf_pkg::SUM_W-1:0]  tat_sum;
    logic [sjf_pkg::SUM_W-1:0]  wait_sum;
    bit                         ran [sjf_pkg::MAX_PROCESSES];
    sjf_pkg::segment_t          segs [2*sjf_pkg::MAX_PROCESSES];
    sjf_pkg::segment_t          seg;
    int                         n;
    int                         completed;
    int                         k;
    int                         best;
    bit                         found;
    bit                         any;
    // a full store drops the job but still honors its final flag
    if (held_count < sjf_pkg::MAX_PROCESSES) begin
      held_arrival[held_count] = j.arrival_time;
      held_burst[held_count] = j.burst_time;
      held_count++;
    end else begin
      dropped_jobs++;
    end
    if (!j.final_job)
      return;

    n = held_count;
    now = '0;
    tat_sum = '0;
    wait_sum = '0;
    completed = 0;
    k = 0;
    for (int i = 0; i < sjf_pkg::MAX_PROCESSES; i++)
      ran[i] = 1'b0;

    while (completed < n) begin
      found = 1'b0;
      best = 0;
      // shortest burst among arrived jobs, then earliest arrival, then lowest index
      for (int i = 0; i < n; i++) begin
        if (ran[i] || sjf_pkg::TIME_W'(held_arrival[i]) > now)
          continue;
        if (!found || held_burst[i] < held_burst[best] ||
            (held_burst[i] == held_burst[best] && held_arrival[i] < held_arrival[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      seg = '0;
      if (found) begin
        seg_start = now;
        now = now + sjf_pkg::TIME_W'(held_burst[best]);
        tat = now - sjf_pkg::TIME_W'(held_arrival[best]);
        wt = tat - sjf_pkg::TIME_W'(held_burst[best]);
        tat_sum = tat_sum + sjf_pkg::SUM_W'(tat);
        wait_sum = wait_sum + sjf_pkg::SUM_W'(wt);
        ran[best] = 1'b1;
        completed++;
        seg.job_number = sjf_pkg::JOB_W'(best + 1);
        seg.start_time = seg_start;
        seg.end_time = now;
        seg.turnaround = tat;
        seg.waiting = wt;
      end else begin
        // nothing ready: one merged gap up to the earliest pending arrival
        any = 1'b0;
        next_arrival = '0;
        for (int i = 0; i < n; i++) begin
          if (!ran[i] && (!any || sjf_pkg::TIME_W'(held_arrival[i]) < next_arrival)) begin
            next_arrival = sjf_pkg::TIME_W'(held_arrival[i]);
            any = 1'b1;
          end
        end
        if (!any || next_arrival <= now)
          break;
        seg.is_idle = 1'b1;
        seg.start_time = now;
        seg.end_time = next_arrival;
        now = next_arrival;
      end
      segs[k] = seg;
      k++;
    end

    if (k > 0) begin
      seg = segs[k-1];
      seg.total_turnaround = tat_sum;
      seg.total_waiting = wait_sum;
      seg.last_segment = 1'b1;
      segs[k-1] = seg;
    end
    for (int i = 0; i < k; i++)
      pending_segments.push_back(segs[i]);
    held_count = 0;
    sets_scheduled++;
  endtask

  function automatic sjf_pkg::job_t make_job(input int unsigned arrival,
                                             input int unsigned burst, input bit last);
    sjf_pkg::job_t j;
    j.arrival_time = arrival[sjf_pkg::DATA_W-1:0];
    j.burst_time = burst[sjf_pkg::DATA_W-1:0];
    j.final_job = last;
    return j;
  endfunction

  // send one item: optional hold-off, wait out busy, present it until taken.
  // returns at the falling edge after acceptance with start still high, so a
  // back-to-back item never lowers and raises start in one step
  task automatic send_job(input sjf_pkg::job_t j, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    job <= j;
    // busy was low at this falling edge and only moves on a rising one
    @(posedge clk);
    predict_item(j);
    items_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every owed segment has arrived
  task automatic wait_all_segments();
    start <= 1'b0;
    @(negedge clk);
    while (pending_segments.size() > 0 || busy)
      @(negedge clk);
  endtask

  // segment checker: every strobed segment against the oldest prediction
  always @(posedge clk) begin
    sjf_pkg::segment_t want;
    if (!rst && valid) begin
      segments_seen++;
      if (segment.is_idle === 1'b1)
        idle_gaps_seen++;
      if (pending_segments.size() == 0) begin
        report_mismatch("segment with nothing owed, job_number",
                        32'(segment.job_number), 0);
      end else begin
        want = pending_segments.pop_front();
        if (segment.is_idle !== want.is_idle)
          report_mismatch("is_idle", 32'(segment.is_idle), 32'(want.is_idle));
        if (segment.job_number !== want.job_number)
          report_mismatch("job_number", 32'(segment.job_number), 32'(want.job_number));
        if (segment.start_time !== want.start_time)
          report_mismatch("start_time", 32'(segment.start_time), 32'(want.start_time));
        if (segment.end_time !== want.end_time)
          report_mismatch("end_time", 32'(segment.end_time), 32'(want.end_time));
        if (segment.turnaround !== want.turnaround)
          report_mismatch("turnaround", 32'(segment.turnaround), 32'(want.turnaround));
        if (segment.waiting !== want.waiting)
          report_mismatch("waiting", 32'(segment.waiting), 32'(want.waiting));
        if (segment.total_turnaround !== want.total_turnaround)
          report_mismatch("total_turnaround", 32'(segment.total_turnaround),
                          32'(want.total_turnaround));
        if (segment.total_waiting !== want.total_waiting)
          report_mismatch("total_waiting", 32'(segment.total_waiting),
                          32'(want.total_waiting));
        if (segment.last_segment !== want.last_segment)
          report_mismatch("last_segment", 32'(segment.last_segment),
                          32'(want.last_segment));
      end
    end
  end

  // watchdog: cycles with no accepted item and no segment
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // late arrivals force merged idle gaps, and the last two jobs tie fully
  task automatic test_idle_gaps();
    send_job(make_job(10, 5, 1'b0), $urandom_range(0, 13));
    send_job(make_job(100, 3, 1'b0), $urandom_range(0, 13));
    send_job(make_job(100, 3, 1'b1), $urandom_range(0, 13));
  endtask

  // zero bursts and all-ones arrival and burst fields
  task automatic test_zero_and_max();
    send_job(make_job(16'hffff, 16'hffff, 1'b0), 0);
    send_job(make_job(0, 0, 1'b0), 0);
    send_job(make_job(16'hffff, 0, 1'b1), 0);
  endtask

  // sixteen jobs with burst ties, arrival ties and full ties, then a dropped
  // plain job and a dropped final job that still starts the schedule
  task automatic test_full_set();
    for (int i = 0; i < sjf_pkg::MAX_PROCESSES; i++)
      send_job(make_job((i * 7) % 12, (i * 5) % 6, 1'b0), $urandom_range(0, 3));
    send_job(make_job(3, 1, 1'b0), 0);
    send_job(make_job(0, 0, 1'b1), 0);
  endtask

  // random job sets in three flavors until the item count is reached
  task automatic test_random_sets();
    int set_size;
    int flavor;
    int set_index;
    bit quiet;
    int unsigned arrival;
    int unsigned burst;
    set_index = 0;
    while (items_sent < ITEM_TARGET) begin
      // mostly legal sizes, now and then an overfull set
      set_size = ($urandom_range(0, 9) == 0) ?
                 $urandom_range(sjf_pkg::MAX_PROCESSES + 1, sjf_pkg::MAX_PROCESSES + 3) :
                 $urandom_range(1, sjf_pkg::MAX_PROCESSES);
      flavor = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_size; i++) begin
        unique case (flavor)
          0: begin
            // dense small values: many ties of every kind
            arrival = $urandom_range(0, 30);
            burst = $urandom_range(0, 8);
          end
          1: begin
            // full range on both fields
            arrival = $urandom_range(0, 65535);
            burst = $urandom_range(0, 65535);
          end
          default: begin
            // spread arrivals, short bursts: mostly idle gaps between jobs
            arrival = $urandom_range(0, 65535);
            burst = $urandom_range(0, 50);
          end
        endcase
        send_job(make_job(arrival, burst, i == set_size - 1),
                 quiet ? 0 : $urandom_range(0, 13));
      end
      if (set_index % 5 == 2)
        wait_all_segments();
      set_index++;
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    job = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_gaps();
    test_zero_and_max();
    test_full_set();
    test_random_sets();

    // drain, then watch a while for anything extra
    wait_all_segments();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d items in %0d job sets, %0d jobs dropped by a full store",
             items_sent, sets_scheduled, dropped_jobs);
    $display("checked %0d segments, %0d of them idle gaps, %0d mismatches",
             segments_seen, idle_gaps_seen, mismatches);
    if (mismatches == 0 && pending_segments.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
